### src/mcsr_pkg.sv
`default_nettype none
package mcsr_pkg;

	localparam int CH_W      = 3;
	localparam int POS_W     = 16;
	localparam int VAL_W     = 24;
	localparam int ELA_W     = 20;
	localparam int ST_W      = 2;
	localparam int ACT_W     = 3;
	localparam int SLOTS     = 1 << CH_W;
	localparam int CFG_IDX_W = 4;
	localparam int PROD_W    = POS_W + ELA_W;

	localparam logic [ACT_W-1:0] ACT_ADD        = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET_TARGET = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET_SMOOTH = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK       = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SUSPEND    = 3'd5;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_ABSENT  = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP     = 2'd2;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_POS      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SMOOTH = 4'd1;

	localparam logic [POS_W-1:0] NEUTRAL = 16'h8000;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_REMOVE,
		OP_SET_TARGET,
		OP_SET_SMOOTH,
		OP_TICK,
		OP_SUSPEND,
		OP_INVALID
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CH_W-1:0]  ch;
		logic             inr;
		logic [VAL_W-1:0] value;
		logic [ELA_W-1:0] elapsed;
	} cmd_t;

endpackage
`default_nettype wire

### src/mcsr_if.sv
`default_nettype none
interface mcsr_in_if;
	logic                       valid;
	logic                       ready;
	logic [mcsr_pkg::ACT_W-1:0] action;
	logic [mcsr_pkg::CH_W-1:0]  channel;
	logic [mcsr_pkg::VAL_W-1:0] value;
	logic [mcsr_pkg::ELA_W-1:0] elapsed;
	modport source (output valid, action, channel, value, elapsed, input ready);
	modport sink (input valid, action, channel, value, elapsed, output ready);
endinterface

interface mcsr_out_if;
	logic                       valid;
	logic                       ready;
	logic [mcsr_pkg::ST_W-1:0]  status;
	logic [mcsr_pkg::CH_W-1:0]  channel_out;
	logic [mcsr_pkg::POS_W-1:0] position;
	logic                       moving;
	modport source (output valid, status, channel_out, position, moving, input ready);
	modport sink (input valid, status, channel_out, position, moving, output ready);
endinterface

interface mcsr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mcsr_pkg::CFG_IDX_W-1:0] index;
	logic [mcsr_pkg::VAL_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/mcsr_front.sv
`default_nettype none
module mcsr_front #(
	parameter int NUM_CHANNELS = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	mcsr_in_if.sink          items,
	output mcsr_pkg::cmd_t   cmd_s1,
	output logic             cmd_valid_s1,
	input  wire              cmd_ready
);

	mcsr_pkg::op_t op;

	always_comb begin
		unique case (items.action)
			mcsr_pkg::ACT_ADD:        op = mcsr_pkg::OP_ADD;
			mcsr_pkg::ACT_REMOVE:     op = mcsr_pkg::OP_REMOVE;
			mcsr_pkg::ACT_SET_TARGET: op = mcsr_pkg::OP_SET_TARGET;
			mcsr_pkg::ACT_SET_SMOOTH: op = mcsr_pkg::OP_SET_SMOOTH;
			mcsr_pkg::ACT_TICK:       op = mcsr_pkg::OP_TICK;
			mcsr_pkg::ACT_SUSPEND:    op = mcsr_pkg::OP_SUSPEND;
			default:                  op = mcsr_pkg::OP_INVALID;
		endcase
	end

	assign items.ready = !cmd_valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			cmd_valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1.op      <= op;
			cmd_s1.ch      <= items.channel;
			cmd_s1.inr     <= (32'(items.channel) < NUM_CHANNELS);
			cmd_s1.value   <= items.value;
			cmd_s1.elapsed <= items.elapsed;
		end
	end

endmodule
`default_nettype wire

### src/mcsr_queue.sv
`default_nettype none
module mcsr_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  mcsr_pkg::cmd_t  wr_cmd,
	input  wire             wr_valid,
	output logic            wr_ready,
	output mcsr_pkg::cmd_t  rd_cmd,
	output logic            rd_valid,
	input  wire             rd_ready
);

	mcsr_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule
`default_nettype wire

### src/mcsr_back.sv
`default_nettype none
module mcsr_back #(
	parameter int MIN_SMOOTH_US = 10000
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  mcsr_pkg::cmd_t               cmd,
	input  wire                          cmd_valid,
	output logic                         cmd_ready,
	input  wire [mcsr_pkg::POS_W-1:0]    reset_position,
	input  wire [mcsr_pkg::VAL_W-1:0]    default_smoothing,
	mcsr_out_if.source                   results
);

	localparam int POS_W  = mcsr_pkg::POS_W;
	localparam int VAL_W  = mcsr_pkg::VAL_W;
	localparam int PROD_W = mcsr_pkg::PROD_W;
	localparam int SLOTS  = mcsr_pkg::SLOTS;
	localparam int CNT_W  = $clog2(PROD_W);
	localparam int NP_W   = PROD_W + 2;
	localparam logic [VAL_W-1:0] MIN_ST = VAL_W'(MIN_SMOOTH_US);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

	state_t state_q;

	logic             present_q [SLOTS];
	logic [POS_W-1:0] prev_q    [SLOTS];
	logic [POS_W-1:0] tgt_q     [SLOTS];
	logic [POS_W-1:0] pos_q     [SLOTS];
	logic [VAL_W-1:0] stime_q   [SLOTS];
	logic             son_q     [SLOTS];

	logic [mcsr_pkg::CH_W-1:0]  tch_q;
	logic [mcsr_pkg::ELA_W-1:0] ela_q;
	logic [POS_W-1:0]           mag_q;
	logic [POS_W-1:0]           lo_q;
	logic [POS_W-1:0]           hi_q;
	logic                       up_q;
	logic [VAL_W-1:0]           divisor_q;
	logic [PROD_W-1:0]          num_q;
	logic [VAL_W-1:0]           rem_q;
	logic [CNT_W-1:0]           cnt_q;

	logic                       out_valid_q;
	logic [mcsr_pkg::ST_W-1:0]  status_q;
	logic [mcsr_pkg::CH_W-1:0]  ch_out_q;
	logic [POS_W-1:0]           position_q;
	logic                       moving_q;

	logic             out_free;
	logic             pop;
	logic             here;
	logic [POS_W-1:0] sat_val;
	logic [POS_W-1:0] cur_prev;
	logic [POS_W-1:0] cur_tgt;
	logic [VAL_W:0]   rem_sh;
	logic             ge;
	logic [VAL_W-1:0] rem_nx;
	logic signed [NP_W-1:0] np;
	logic signed [NP_W-1:0] lo_x;
	logic signed [NP_W-1:0] hi_x;

	function automatic logic [VAL_W-1:0] clamp_smooth(input logic [VAL_W-1:0] v);
		return (v < MIN_ST) ? MIN_ST : v;
	endfunction

	assign out_free  = !out_valid_q || results.ready;
	assign pop       = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cmd_ready = pop;
	assign here      = cmd.inr && present_q[cmd.ch];
	assign sat_val   = (cmd.value > VAL_W'(16'hFFFF)) ? 16'hFFFF : cmd.value[POS_W-1:0];
	assign cur_prev  = prev_q[cmd.ch];
	assign cur_tgt   = tgt_q[cmd.ch];

	// one restoring division step per cycle
	always_comb begin
		rem_sh = {rem_q, num_q[PROD_W-1]};
		ge     = (rem_sh >= {1'b0, divisor_q});
		rem_nx = ge ? VAL_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[VAL_W-1:0];
	end

	always_comb begin
		lo_x = signed'({{(NP_W-POS_W){1'b0}}, lo_q});
		hi_x = signed'({{(NP_W-POS_W){1'b0}}, hi_q});
		if (up_q) begin
			np = signed'({{(NP_W-POS_W){1'b0}}, pos_q[tch_q]}) + signed'({2'b00, num_q});
		end else begin
			np = signed'({{(NP_W-POS_W){1'b0}}, pos_q[tch_q]}) - signed'({2'b00, num_q});
		end
	end

	assign results.valid       = out_valid_q;
	assign results.status      = status_q;
	assign results.channel_out = ch_out_q;
	assign results.position    = position_q;
	assign results.moving      = moving_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= mcsr_pkg::ST_OK;
			ch_out_q    <= '0;
			position_q  <= '0;
			moving_q    <= 1'b0;
			tch_q       <= '0;
			ela_q       <= '0;
			mag_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			up_q        <= 1'b0;
			divisor_q   <= MIN_ST;
			num_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				present_q[i] <= 1'b0;
				prev_q[i]    <= mcsr_pkg::NEUTRAL;
				tgt_q[i]     <= mcsr_pkg::NEUTRAL;
				pos_q[i]     <= mcsr_pkg::NEUTRAL;
				stime_q[i]   <= MIN_ST;
				son_q[i]     <= 1'b0;
			end
		end else begin
			if (results.valid && results.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						out_valid_q <= 1'b1;
						ch_out_q    <= cmd.ch;
						status_q    <= mcsr_pkg::ST_OK;
						position_q  <= '0;
						moving_q    <= 1'b0;
						unique case (cmd.op)
							mcsr_pkg::OP_ADD: begin
								if (!cmd.inr) begin
									status_q <= mcsr_pkg::ST_ABSENT;
								end else if (here) begin
									status_q <= mcsr_pkg::ST_DUP;
								end else begin
									present_q[cmd.ch] <= 1'b1;
									prev_q[cmd.ch]    <= mcsr_pkg::NEUTRAL;
									tgt_q[cmd.ch]     <= mcsr_pkg::NEUTRAL;
									pos_q[cmd.ch]     <= mcsr_pkg::NEUTRAL;
									son_q[cmd.ch]     <= (default_smoothing != '0);
									stime_q[cmd.ch]   <= clamp_smooth(default_smoothing);
									position_q        <= mcsr_pkg::NEUTRAL;
								end
							end
							mcsr_pkg::OP_REMOVE: begin
								if (cmd.inr) begin
									present_q[cmd.ch] <= 1'b0;
									position_q        <= pos_q[cmd.ch];
								end
							end
							mcsr_pkg::OP_SET_TARGET: begin
								if (!here) begin
									status_q <= mcsr_pkg::ST_ABSENT;
								end else begin
									prev_q[cmd.ch] <= cur_tgt;
									tgt_q[cmd.ch]  <= sat_val;
									position_q     <= son_q[cmd.ch] ? pos_q[cmd.ch] : sat_val;
								end
							end
							mcsr_pkg::OP_SET_SMOOTH: begin
								if (!here) begin
									status_q <= mcsr_pkg::ST_ABSENT;
								end else begin
									son_q[cmd.ch]   <= (cmd.value != '0);
									stime_q[cmd.ch] <= clamp_smooth(cmd.value);
									position_q      <= pos_q[cmd.ch];
								end
							end
							mcsr_pkg::OP_TICK: begin
								if (!here) begin
									status_q <= mcsr_pkg::ST_ABSENT;
								end else if (!son_q[cmd.ch]) begin
									pos_q[cmd.ch] <= cur_tgt;
									position_q    <= cur_tgt;
								end else begin
									// hold the result until the division is done
									out_valid_q <= 1'b0;
									tch_q       <= cmd.ch;
									ela_q       <= cmd.elapsed;
									up_q        <= (cur_tgt >= cur_prev);
									mag_q       <= (cur_tgt >= cur_prev) ? cur_tgt - cur_prev
									                                     : cur_prev - cur_tgt;
									lo_q        <= (cur_prev < cur_tgt) ? cur_prev : cur_tgt;
									hi_q        <= (cur_prev > cur_tgt) ? cur_prev : cur_tgt;
									divisor_q   <= stime_q[cmd.ch];
									state_q     <= S_MUL;
								end
							end
							mcsr_pkg::OP_SUSPEND: begin
								for (int i = 0; i < SLOTS; i++) begin
									if (present_q[i]) begin
										prev_q[i] <= reset_position;
										tgt_q[i]  <= reset_position;
										pos_q[i]  <= reset_position;
									end
								end
								position_q <= reset_position;
							end
							default: begin
								status_q <= mcsr_pkg::ST_INVALID;
							end
						endcase
					end
				end
				S_MUL: begin
					num_q   <= PROD_W'(mag_q) * PROD_W'(ela_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					num_q <= {num_q[PROD_W-2:0], ge};
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PROD_W - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ch_out_q    <= tch_q;
						status_q    <= mcsr_pkg::ST_OK;
						if (np < lo_x) begin
							pos_q[tch_q] <= lo_q;
							position_q   <= lo_q;
							moving_q     <= 1'b0;
						end else if (np > hi_x) begin
							pos_q[tch_q] <= hi_q;
							position_q   <= hi_q;
							moving_q     <= 1'b0;
						end else begin
							pos_q[tch_q] <= np[POS_W-1:0];
							position_q   <= np[POS_W-1:0];
							moving_q     <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/multi_channel_servo_slew_ramp.sv
// An item is registered in the front stage, queued, and its result registered at output;
// a smoothed tick passes S_MUL, a 36-step serial divider (one quotient bit a cycle), S_FIN.
// Throughput: one item per cycle, while results are not stalled, for every action but a
// smoothed tick; that holds the execution side while the input queues up to three items.
// Reset (arst_n low, asynchronous): all channels absent at neutral position, registers at
// their reset values, pipeline and queue empty.
`default_nettype none
module multi_channel_servo_slew_ramp #(
	parameter int NUM_CHANNELS  = 8,
	parameter int MIN_SMOOTH_US = 10000
) (
	input  wire         clk,
	input  wire         arst_n,
	mcsr_in_if.sink     items,
	mcsr_out_if.source  results,
	mcsr_cfg_if.sink    cfg
);

	mcsr_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;
	mcsr_pkg::cmd_t head_cmd;
	logic           head_valid;
	logic           head_ready;

	logic [mcsr_pkg::POS_W-1:0] reset_position_q;
	logic [mcsr_pkg::VAL_W-1:0] default_smoothing_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_position_q    <= mcsr_pkg::NEUTRAL;
			default_smoothing_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				mcsr_pkg::CFG_RESET_POS:      reset_position_q <= cfg.data[mcsr_pkg::POS_W-1:0];
				mcsr_pkg::CFG_DEFAULT_SMOOTH: default_smoothing_q <= cfg.data;
				default: ;
			endcase
		end
	end

	mcsr_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.cmd_s1      (front_cmd),
		.cmd_valid_s1(front_valid),
		.cmd_ready   (front_ready)
	);

	mcsr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cmd  (front_cmd),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.rd_cmd  (head_cmd),
		.rd_valid(head_valid),
		.rd_ready(head_ready)
	);

	mcsr_back #(
		.MIN_SMOOTH_US(MIN_SMOOTH_US)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (head_cmd),
		.cmd_valid        (head_valid),
		.cmd_ready        (head_ready),
		.reset_position   (reset_position_q),
		.default_smoothing(default_smoothing_q),
		.results          (results)
	);

endmodule
`default_nettype wire

### tb/tb_multi_channel_servo_slew_ramp.sv
`default_nettype none
module tb_multi_channel_servo_slew_ramp;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 8;
	localparam int MIN_SMOOTH = 10000;
	localparam longint CYCLE_LIMIT = 600000;
	localparam int POS_W = mcsr_pkg::POS_W;
	localparam int VAL_W = mcsr_pkg::VAL_W;
	localparam int ELA_W = mcsr_pkg::ELA_W;
	localparam int ACT_W = mcsr_pkg::ACT_W;
	localparam int CH_W  = mcsr_pkg::CH_W;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [CH_W-1:0]  channel;
		logic [VAL_W-1:0] value;
		logic [ELA_W-1:0] elapsed;
	} servo_cmd_t;

	typedef struct packed {
		logic [mcsr_pkg::ST_W-1:0] status;
		logic [CH_W-1:0]           channel;
		logic [POS_W-1:0]          position;
		logic                      moving;
	} servo_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mcsr_in_if  items ();
	mcsr_out_if results ();
	mcsr_cfg_if cfg ();

	multi_channel_servo_slew_ramp dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items.sink),
		.results (results.source),
		.cfg     (cfg.sink)
	);

	always #5 clk = ~clk;

	// shadow of the channel table
	logic             m_present  [NCH];
	logic [POS_W-1:0] m_prev     [NCH];
	logic [POS_W-1:0] m_tgt      [NCH];
	logic [POS_W-1:0] m_pos      [NCH];
	logic [VAL_W-1:0] m_smooth   [NCH];
	logic             m_smooth_on[NCH];
	logic [POS_W-1:0] m_reset_pos;
	logic [VAL_W-1:0] m_default_smooth;

	servo_cmd_t pending_cmds[$];
	servo_res_t expected_res[$];
	int         mismatches = 0;
	longint     cycles = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	bit         hold_send = 1'b0;

	function automatic logic [VAL_W-1:0] raise_smooth(logic [VAL_W-1:0] v);
		return (v < MIN_SMOOTH) ? VAL_W'(MIN_SMOOTH) : v;
	endfunction

	function automatic void clear_slot(int c);
		m_present[c] = 1'b0;
		m_prev[c] = mcsr_pkg::NEUTRAL;
		m_tgt[c] = mcsr_pkg::NEUTRAL;
		m_pos[c] = mcsr_pkg::NEUTRAL;
		m_smooth[c] = VAL_W'(MIN_SMOOTH);
		m_smooth_on[c] = 1'b0;
	endfunction

	function automatic servo_res_t predict_servo(servo_cmd_t cmd);
		servo_res_t r;
		int c;
		longint p, t, lo, hi, np, mag, q;
		c = cmd.channel;
		r = '0;
		r.channel = cmd.channel;
		r.status = mcsr_pkg::ST_OK;
		case (cmd.action)
			mcsr_pkg::ACT_ADD: begin
				if (m_present[c]) begin
					r.status = mcsr_pkg::ST_DUP;
				end else begin
					clear_slot(c);
					m_present[c] = 1'b1;
					m_smooth_on[c] = (m_default_smooth != 0);
					m_smooth[c] = raise_smooth(m_default_smooth);
					r.position = m_pos[c];
				end
			end
			mcsr_pkg::ACT_REMOVE: begin
				m_present[c] = 1'b0;
				r.position = m_pos[c];
			end
			mcsr_pkg::ACT_SET_TARGET: begin
				if (!m_present[c]) begin
					r.status = mcsr_pkg::ST_ABSENT;
				end else begin
					m_prev[c] = m_tgt[c];
					m_tgt[c] = (cmd.value > 24'hFFFF) ? 16'hFFFF : cmd.value[POS_W-1:0];
					r.position = m_smooth_on[c] ? m_pos[c] : m_tgt[c];
				end
			end
			mcsr_pkg::ACT_SET_SMOOTH: begin
				if (!m_present[c]) begin
					r.status = mcsr_pkg::ST_ABSENT;
				end else begin
					m_smooth_on[c] = (cmd.value != 0);
					m_smooth[c] = raise_smooth(cmd.value);
					r.position = m_pos[c];
				end
			end
			mcsr_pkg::ACT_TICK: begin
				if (!m_present[c]) begin
					r.status = mcsr_pkg::ST_ABSENT;
				end else if (!m_smooth_on[c]) begin
					m_pos[c] = m_tgt[c];
					r.position = m_pos[c];
				end else begin
					p = m_prev[c];
					t = m_tgt[c];
					mag = (t >= p) ? t - p : p - t;
					q = (mag * longint'(cmd.elapsed)) / longint'(m_smooth[c]);
					np = longint'(m_pos[c]) + ((t >= p) ? q : -q);
					lo = (p < t) ? p : t;
					hi = (p > t) ? p : t;
					r.moving = 1'b1;
					if (np < lo) begin
						np = lo;
						r.moving = 1'b0;
					end else if (np > hi) begin
						np = hi;
						r.moving = 1'b0;
					end
					m_pos[c] = POS_W'(np);
					r.position = m_pos[c];
				end
			end
			mcsr_pkg::ACT_SUSPEND: begin
				for (int i = 0; i < NCH; i++) begin
					if (m_present[i]) begin
						m_prev[i] = m_reset_pos;
						m_tgt[i] = m_reset_pos;
						m_pos[i] = m_reset_pos;
					end
				end
				r.position = m_reset_pos;
			end
			default: r.status = mcsr_pkg::ST_INVALID;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
			items.action <= '0;
			items.channel <= '0;
			items.value <= '0;
			items.elapsed <= '0;
		end else if (!items.valid || items.ready) begin
			if (items.valid)
				expected_res.push_back(predict_servo({items.action, items.channel,
					items.value, items.elapsed}));
			if (pending_cmds.size() > 0 && !hold_send &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				servo_cmd_t c;
				c = pending_cmds.pop_front();
				items.valid <= 1'b1;
				{items.action, items.channel, items.value, items.elapsed} <= c;
			end else begin
				items.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			cycles++;
			if (results.valid && results.ready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected result, channel", results.channel_out, -1);
				end else begin
					servo_res_t e;
					e = expected_res.pop_front();
					if (results.status !== e.status)
						report_mismatch("status", results.status, e.status);
					if (results.channel_out !== e.channel)
						report_mismatch("channel", results.channel_out, e.channel);
					if (results.position !== e.position)
						report_mismatch("position", results.position, e.position);
					if (results.moving !== e.moving)
						report_mismatch("moving", results.moving, e.moving);
				end
			end
			results.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_cmds.size() > 0 || items.valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [mcsr_pkg::CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == mcsr_pkg::CFG_RESET_POS)
			m_reset_pos = data[POS_W-1:0];
		else
			m_default_smooth = data;
	endtask

	function automatic servo_cmd_t mk(logic [ACT_W-1:0] a, int ch, logic [VAL_W-1:0] v,
			logic [ELA_W-1:0] el);
		servo_cmd_t c;
		c.action = a;
		c.channel = CH_W'(ch);
		c.value = v;
		c.elapsed = el;
		return c;
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(4, 0))
			0: return VAL_W'($urandom_range(20000, 0));
			1: return 24'hFFFFFF;
			2: return 24'h0;
			3: return VAL_W'($urandom_range(65535, 0));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [ELA_W-1:0] rand_elapsed();
		case ($urandom_range(3, 0))
			0: return ELA_W'($urandom_range(5000, 0));
			1: return 20'hFFFFF;
			default: return ELA_W'($urandom);
		endcase
	endfunction

	// mostly well-formed: every action kind, plus add, target, tick runs
	task automatic queue_random(int n);
		int ch;
		for (int i = 0; i < n; i++) begin
			ch = $urandom_range(NCH - 1, 0);
			case ($urandom_range(9, 0))
				0: pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, ch, rand_value(),
					rand_elapsed()));
				1: pending_cmds.push_back(mk(mcsr_pkg::ACT_REMOVE, ch, rand_value(),
					rand_elapsed()));
				2, 3: pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, ch, rand_value(),
					rand_elapsed()));
				4: pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_SMOOTH, ch, rand_value(),
					rand_elapsed()));
				5, 6, 7: pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, ch, rand_value(),
					rand_elapsed()));
				8: pending_cmds.push_back(mk($urandom_range(1, 0) ? mcsr_pkg::ACT_SUSPEND :
					ACT_W'($urandom_range(7, 6)), ch, rand_value(), rand_elapsed()));
				default: begin
					pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, ch, 0, 0));
					pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, ch, rand_value(), 0));
					repeat ($urandom_range(3, 1))
						pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, ch, 0, rand_elapsed()));
				end
			endcase
		end
	endtask

	initial begin
		items.valid = 1'b0;
		items.action = '0;
		items.channel = '0;
		items.value = '0;
		items.elapsed = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		for (int i = 0; i < NCH; i++) clear_slot(i);
		m_reset_pos = mcsr_pkg::NEUTRAL;
		m_default_smooth = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default smoothing off, then on
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 0, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 0, 100, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, 0, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, 0, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 0, 24'hFFFFFF, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 0, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_SMOOTH, 0, 1, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 0, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 0, 0, 1000));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 0, 0, 20'hFFFFF));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, 7, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_SMOOTH, 7, 24'hFFFFFF, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 7, 65535, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 7, 0, 20'hFFFFF));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_SMOOTH, 7, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 7, 5, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SUSPEND, 3, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_REMOVE, 7, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_REMOVE, 7, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_SMOOTH, 7, 5, 0));
		pending_cmds.push_back(mk(3'd6, 2, 24'hABCDEF, 20'h12345));
		pending_cmds.push_back(mk(3'd7, 5, 24'h543210, 20'hEDCBA));
		drain();

		write_reg(mcsr_pkg::CFG_RESET_POS, 24'h0);
		write_reg(mcsr_pkg::CFG_DEFAULT_SMOOTH, 24'd50000);
		pending_cmds.push_back(mk(mcsr_pkg::ACT_ADD, 1, 0, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SET_TARGET, 1, 40000, 0));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_TICK, 1, 0, 10000));
		pending_cmds.push_back(mk(mcsr_pkg::ACT_SUSPEND, 1, 0, 0));
		queue_random(40);
		drain();

		write_reg(mcsr_pkg::CFG_RESET_POS, 24'hFFFF);
		write_reg(mcsr_pkg::CFG_DEFAULT_SMOOTH, 24'hFFFFFF);
		send_idle_pct = 81;
		queue_random(65);
		drain();

		// hold the sender mid-stream until every result is back, then resume
		queue_random(15);
		repeat (20) @(posedge clk);
		hold_send = 1'b1;
		while (items.valid || expected_res.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		hold_send = 1'b0;
		drain();

		write_reg(mcsr_pkg::CFG_DEFAULT_SMOOTH, 24'd1);
		write_reg(mcsr_pkg::CFG_RESET_POS, VAL_W'($urandom_range(65535, 0)));
		send_idle_pct = 0;
		recv_stall_pct = 81;
		queue_random(65);
		drain();

		write_reg(mcsr_pkg::CFG_DEFAULT_SMOOTH, 24'd0);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		queue_random(65);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(40);
		drain();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
